@@ rtl/core/preemptive_priority_scheduler_macros.svh @@
// Assertion macros used by the scheduler top module.
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_MACROS_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checks a property on every clock edge outside of reset.
`define PPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition on one edge is followed by another on the next edge.
`define PPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define PPS_ASSERT(lbl, prop, msg)
`define PPS_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

@@ rtl/core/pps_pkg.sv @@
package pps_pkg;

  localparam int TASK_SLOTS = 16;
  localparam int SLOT_W     = $clog2(TASK_SLOTS);

  typedef logic [SLOT_W-1:0] slot_idx_t;

  typedef enum logic {
    CMD_ADD  = 1'b0,
    CMD_TICK = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_FULL = 2'd1,
    STATUS_IDLE = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  typedef struct packed {
    cmd_e        command;
    logic [7:0]  task_priority;
    logic [15:0] burst_length;
  } in_item_t;

  typedef struct packed {
    status_e     status;
    logic [3:0]  slot;
    logic        task_done;
    logic [31:0] time_now;
  } out_item_t;

  // Best candidate seen so far as the scan wave moves along the cells.
  typedef struct packed {
    logic        found;
    slot_idx_t   idx;
    logic [7:0]  prio;
    logic [31:0] age;
    logic        running;
    logic [15:0] rem;
  } cand_t;

  // Context that holds still during one scan.
  typedef struct packed {
    logic        tick;
    logic        hi_wins;
    logic        run_valid;
    slot_idx_t   run_idx;
    logic [31:0] add_count;
  } scan_ctl_t;

  // Update broadcast to the cells when an item finishes.
  typedef struct packed {
    logic        add_en;
    logic        tick_en;
    slot_idx_t   idx;
    logic [7:0]  prio;
    logic [15:0] burst;
  } commit_t;

endpackage

@@ rtl/core/pps_cell.sv @@
module pps_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pps_pkg::slot_idx_t cell_idx_i,
  input  pps_pkg::scan_ctl_t ctl_i,
  input  pps_pkg::commit_t   commit_i,
  input  logic               wave_valid_i,
  input  pps_pkg::cand_t     cand_i,
  output logic               wave_valid_o,
  output pps_pkg::cand_t     cand_o,
  output logic               slot_valid_o
);

  logic           valid_q;
  logic [7:0]     prio_q;
  logic [15:0]    rem_q;
  logic [31:0]    stamp_q;
  logic           wave_valid_q;
  pps_pkg::cand_t cand_q;
  pps_pkg::cand_t cand_d;

  logic [31:0] own_age;
  logic        own_run;
  logic        prio_better;
  logic        take;
  logic        hit;

  assign own_age = ctl_i.add_count - stamp_q;
  assign own_run = ctl_i.run_valid && (ctl_i.run_idx == cell_idx_i);
  assign hit     = (commit_i.idx == cell_idx_i);

  always_comb begin
    prio_better = ctl_i.hi_wins ? (prio_q > cand_i.prio) : (prio_q < cand_i.prio);
    // On a tick the running task beats equal priorities, else the oldest wins; an add takes the first free slot.
    if (ctl_i.tick) begin
      take = valid_q && (!cand_i.found || prio_better ||
             ((prio_q == cand_i.prio) &&
              (own_run || (!cand_i.running && (own_age > cand_i.age)))));
    end else begin
      take = !valid_q && !cand_i.found;
    end
    cand_d = cand_i;
    if (take) begin
      cand_d.found   = 1'b1;
      cand_d.idx     = cell_idx_i;
      cand_d.prio    = prio_q;
      cand_d.age     = own_age;
      cand_d.running = own_run;
      cand_d.rem     = rem_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= 1'b0;
      wave_valid_q <= 1'b0;
    end else begin
      wave_valid_q <= wave_valid_i;
      if (commit_i.add_en && hit) begin
        valid_q <= 1'b1;
      end else if (commit_i.tick_en && hit && (rem_q <= 16'd1)) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wave_valid_i) begin
      cand_q <= cand_d;
    end
    if (commit_i.add_en && hit) begin
      prio_q  <= commit_i.prio;
      rem_q   <= commit_i.burst;
      stamp_q <= ctl_i.add_count;
    end else if (commit_i.tick_en && hit && (rem_q > 16'd1)) begin
      rem_q <= rem_q - 16'd1;
    end
  end

  assign wave_valid_o = wave_valid_q;
  assign cand_o       = cand_q;
  assign slot_valid_o = valid_q;

endmodule

@@ rtl/core/preemptive_priority_scheduler.sv @@
// Preemptive priority scheduler over a row of task slot cells.
// Input channel in_valid_i / in_stall_o carries one item: an add (priority and
// burst length) or a tick. Every item yields exactly one result on out_valid_o /
// out_stall_i: the slot given or run, a status, a done flag and the time count.
// cfg_we_i / cfg_wdata_i write the mode bit (1: largest priority number wins);
// it resets to 1; it is to be written only while the block is idle, which the
// block itself does not enforce. Each item sends a scan wave through the cells,
// one cell per cycle; the result is registered after the wave leaves the last
// cell, and the next item is taken only once that result has been loaded into
// the output register. The length of the cell chain sets the pace.
// A finished result sits in the output register; the block takes the next item
// while it waits, but cannot finish that item until the result has been taken.
// Reset empties every slot, clears the time count and the add order count, sets
// no task running and leaves the output empty.
module preemptive_priority_scheduler (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  pps_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output pps_pkg::out_item_t out_data_o
);

  `include "preemptive_priority_scheduler_macros.svh"

  pps_pkg::state_e    state_q, state_d;
  logic               hi_wins_q;
  pps_pkg::in_item_t  item_q;
  logic [31:0]        time_q;
  logic [31:0]        add_count_q;
  logic               run_valid_q;
  pps_pkg::slot_idx_t run_idx_q;
  logic               out_valid_q;
  pps_pkg::out_item_t out_q;

  logic               accept;
  logic               commit_go;
  logic               busy;
  logic               scanning;
  logic               in_done;
  pps_pkg::scan_ctl_t ctl;
  pps_pkg::commit_t   commit;
  pps_pkg::cand_t     best;
  pps_pkg::out_item_t result;
  logic               best_done;

  logic [pps_pkg::TASK_SLOTS:0] wave_valid;
  pps_pkg::cand_t               cand [pps_pkg::TASK_SLOTS+1];
  logic [pps_pkg::TASK_SLOTS-1:0] slot_valid;

  assign accept = in_valid_i && !in_stall_o;

  assign wave_valid[0] = accept;
  assign cand[0]       = '0;

  // The first cell sees the wave in the transfer cycle, before item_q holds the item.
  assign ctl.tick      = accept ? (in_data_i.command == pps_pkg::CMD_TICK)
                                : (item_q.command == pps_pkg::CMD_TICK);
  assign ctl.hi_wins   = hi_wins_q;
  assign ctl.run_valid = run_valid_q;
  assign ctl.run_idx   = run_idx_q;
  assign ctl.add_count = add_count_q;

  for (genvar g = 0; g < pps_pkg::TASK_SLOTS; g++) begin : g_cell
    pps_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cell_idx_i   (pps_pkg::slot_idx_t'(g)),
      .ctl_i        (ctl),
      .commit_i     (commit),
      .wave_valid_i (wave_valid[g]),
      .cand_i       (cand[g]),
      .wave_valid_o (wave_valid[g+1]),
      .cand_o       (cand[g+1]),
      .slot_valid_o (slot_valid[g])
    );
  end

  // The last cell holds its candidate until the next wave arrives.
  assign best      = cand[pps_pkg::TASK_SLOTS];
  assign best_done = (best.rem <= 16'd1);

  always_comb begin
    state_d = state_q;
    case (state_q)
      pps_pkg::ST_IDLE: begin
        if (accept) state_d = pps_pkg::ST_SCAN;
      end
      pps_pkg::ST_SCAN: begin
        if (wave_valid[pps_pkg::TASK_SLOTS]) state_d = pps_pkg::ST_DONE;
      end
      pps_pkg::ST_DONE: begin
        if (!out_valid_q || !out_stall_i) state_d = pps_pkg::ST_IDLE;
      end
      default: state_d = pps_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy      = 1'b1;
    commit_go = 1'b0;
    case (state_q)
      pps_pkg::ST_IDLE: busy = 1'b0;
      pps_pkg::ST_SCAN: busy = 1'b1;
      pps_pkg::ST_DONE: commit_go = !out_valid_q || !out_stall_i;
      default: busy = 1'b1;
    endcase
  end

  assign in_stall_o = busy;
  assign scanning   = (state_q == pps_pkg::ST_SCAN);
  assign in_done    = (state_q == pps_pkg::ST_DONE);

  always_comb begin
    result.task_done = 1'b0;
    result.slot      = 4'd0;
    if (item_q.command == pps_pkg::CMD_ADD) begin
      result.time_now = time_q;
      if (best.found) begin
        result.status = pps_pkg::STATUS_OK;
        result.slot   = 4'(best.idx);
      end else begin
        result.status = pps_pkg::STATUS_FULL;
      end
    end else begin
      result.time_now = time_q + 32'd1;
      if (best.found) begin
        result.status    = pps_pkg::STATUS_OK;
        result.slot      = 4'(best.idx);
        result.task_done = best_done;
      end else begin
        result.status = pps_pkg::STATUS_IDLE;
      end
    end
  end

  assign commit.add_en  = commit_go && (item_q.command == pps_pkg::CMD_ADD) && best.found;
  assign commit.tick_en = commit_go && (item_q.command == pps_pkg::CMD_TICK) && best.found;
  assign commit.idx     = best.idx;
  assign commit.prio    = item_q.task_priority;
  assign commit.burst   = item_q.burst_length;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pps_pkg::ST_IDLE;
      hi_wins_q   <= 1'b1;
      time_q      <= 32'd0;
      add_count_q <= 32'd0;
      run_valid_q <= 1'b0;
      run_idx_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) hi_wins_q <= cfg_wdata_i;
      if (commit_go) begin
        out_valid_q <= 1'b1;
        if (item_q.command == pps_pkg::CMD_ADD) begin
          if (best.found) add_count_q <= add_count_q + 32'd1;
        end else begin
          time_q <= time_q + 32'd1;
          if (best.found && !best_done) begin
            run_valid_q <= 1'b1;
            run_idx_q   <= best.idx;
          end else begin
            run_valid_q <= 1'b0;
          end
        end
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) item_q <= in_data_i;
    if (commit_go) out_q <= result;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `PPS_ASSERT(a_one_wave, $onehot0(wave_valid), "more than one scan wave in the chain")
  `PPS_ASSERT(a_wave_end_scan, wave_valid[pps_pkg::TASK_SLOTS] |-> scanning, "wave end not in scan")
  `PPS_ASSERT_NEXT(a_accept_scan, accept, scanning, "accepted transfer did not start a scan")
  `PPS_ASSERT(a_run_valid, run_valid_q |-> slot_valid[run_idx_q], "running task in an empty slot")
  `PPS_ASSERT(a_out_from_done, $rose(out_valid_q) |-> $past(in_done), "result loaded outside done")

endmodule

@@ dv/preemptive_priority_scheduler_tb.sv @@
`timescale 1ns / 1ps

module preemptive_priority_scheduler_tb;

  localparam int          SETTLE_CYCLES  = pps_pkg::TASK_SLOTS + 8;
  localparam int unsigned LIMIT_CYCLES   = 400000;
  localparam int          PHASE_ITEMS    = 185;
  localparam int          MAX_REPORTS    = 20;

  typedef struct {
    pps_pkg::in_item_t  item;
    logic               typed;
    pps_pkg::out_item_t want;
  } dir_row_t;

  localparam pps_pkg::out_item_t NO_WANT = '{pps_pkg::STATUS_OK, 4'd0, 1'b0, 32'd0};

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic               cfg_wdata_i;
  logic               in_valid_i;
  logic               in_stall_o;
  pps_pkg::in_item_t  in_data_i;
  logic               out_valid_o;
  logic               out_stall_i;
  pps_pkg::out_item_t out_data_o;

  // Scheduler image kept by the testbench.
  logic        high_wins;
  logic        tsk_valid [pps_pkg::TASK_SLOTS];
  logic [7:0]  tsk_prio  [pps_pkg::TASK_SLOTS];
  logic [15:0] tsk_left  [pps_pkg::TASK_SLOTS];
  logic [31:0] tsk_stamp [pps_pkg::TASK_SLOTS];
  logic        run_valid;
  int unsigned run_slot;
  logic [31:0] sched_now;
  logic [31:0] add_seq;
  int          live_tasks;

  pps_pkg::out_item_t due_results [$];
  pps_pkg::out_item_t want_now;
  int          err_count = 0;
  int          stall_pct;
  int          n_adds, n_full, n_ticks, n_idle, n_finished;
  int unsigned cycle_count = 0;

  logic [7:0] tie_prios [5] = '{8'h00, 8'h01, 8'h80, 8'hfe, 8'hff};

  // Short directed walk: idle tick, zero burst, preemption, ties, fill to full.
  dir_row_t dir_rows [25] = '{
    '{'{pps_pkg::CMD_TICK, 8'h00, 16'h0000}, 1'b1,
      '{pps_pkg::STATUS_IDLE, 4'd0, 1'b0, 32'd1}},
    '{'{pps_pkg::CMD_ADD,  8'hff, 16'h0000}, 1'b1,
      '{pps_pkg::STATUS_OK,   4'd0, 1'b0, 32'd1}},
    '{'{pps_pkg::CMD_TICK, 8'h00, 16'h0000}, 1'b1,
      '{pps_pkg::STATUS_OK,   4'd0, 1'b1, 32'd2}},
    '{'{pps_pkg::CMD_ADD,  8'h00, 16'h0003}, 1'b0, NO_WANT},
    '{'{pps_pkg::CMD_ADD,  8'h00, 16'h0002}, 1'b0, NO_WANT},
    '{'{pps_pkg::CMD_TICK, 8'hff, 16'hffff}, 1'b0, NO_WANT},
    '{'{pps_pkg::CMD_ADD,  8'hff, 16'h0001}, 1'b0, NO_WANT},
    '{'{pps_pkg::CMD_TICK, 8'h00, 16'h0000}, 1'b0, NO_WANT},
    '{'{pps_pkg::CMD_ADD,  8'h7f, 16'hffff}, 1'b0, NO_WANT},
    '{'{pps_pkg::CMD_ADD,  8'h55, 16'h0001}, 1'b0, NO_WANT},
    '{'{pps_pkg::CMD_ADD,  8'haa, 16'h0002}, 1'b0, NO_WANT},
    '{'{pps_pkg::CMD_ADD,  8'h01, 16'h0003}, 1'b0, NO_WANT},
    '{'{pps_pkg::CMD_ADD,  8'hfe, 16'h0004}, 1'b0, NO_WANT},
    '{'{pps_pkg::CMD_ADD,  8'h80, 16'h0001}, 1'b0, NO_WANT},
    '{'{pps_pkg::CMD_ADD,  8'h00, 16'h0002}, 1'b0, NO_WANT},
    '{'{pps_pkg::CMD_ADD,  8'hff, 16'h0001}, 1'b0, NO_WANT},
    '{'{pps_pkg::CMD_ADD,  8'h40, 16'h0003}, 1'b0, NO_WANT},
    '{'{pps_pkg::CMD_ADD,  8'h40, 16'h0002}, 1'b0, NO_WANT},
    '{'{pps_pkg::CMD_ADD,  8'hc0, 16'h0001}, 1'b0, NO_WANT},
    '{'{pps_pkg::CMD_ADD,  8'hc0, 16'h0004}, 1'b0, NO_WANT},
    '{'{pps_pkg::CMD_ADD,  8'h7f, 16'h0002}, 1'b0, NO_WANT},
    '{'{pps_pkg::CMD_ADD,  8'h33, 16'h0001}, 1'b0, NO_WANT},
    '{'{pps_pkg::CMD_ADD,  8'h12, 16'h0005}, 1'b1,
      '{pps_pkg::STATUS_FULL, 4'd0, 1'b0, 32'd4}},
    '{'{pps_pkg::CMD_TICK, 8'h00, 16'h0000}, 1'b0, NO_WANT},
    '{'{pps_pkg::CMD_TICK, 8'hff, 16'hffff}, 1'b0, NO_WANT}
  };

  preemptive_priority_scheduler dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Works out the result of one item and advances the scheduler image.
  function automatic pps_pkg::out_item_t next_schedule_result(pps_pkg::in_item_t it);
    pps_pkg::out_item_t res;
    logic        found;
    logic [7:0]  top_prio;
    int unsigned pick;
    logic [31:0] pick_age;
    logic [31:0] age;
    res.status    = pps_pkg::STATUS_OK;
    res.slot      = '0;
    res.task_done = 1'b0;
    top_prio      = '0;
    pick          = 0;
    pick_age      = '0;
    found         = 1'b0;

    if (it.command == pps_pkg::CMD_ADD) begin
      n_adds++;
      res.status = pps_pkg::STATUS_FULL;
      for (int s = 0; s < pps_pkg::TASK_SLOTS; s++) begin
        if (!tsk_valid[s] && res.status == pps_pkg::STATUS_FULL) begin
          tsk_valid[s] = 1'b1;
          tsk_prio[s]  = it.task_priority;
          tsk_left[s]  = it.burst_length;
          tsk_stamp[s] = add_seq;
          add_seq++;
          live_tasks++;
          res.status = pps_pkg::STATUS_OK;
          res.slot   = 4'(s);
        end
      end
      if (res.status == pps_pkg::STATUS_FULL) n_full++;
      res.time_now = sched_now;
      return res;
    end

    n_ticks++;
    sched_now++;
    res.time_now = sched_now;
    for (int s = 0; s < pps_pkg::TASK_SLOTS; s++) begin
      if (tsk_valid[s] && (!found ||
          (high_wins ? (tsk_prio[s] > top_prio) : (tsk_prio[s] < top_prio)))) begin
        found    = 1'b1;
        top_prio = tsk_prio[s];
      end
    end
    if (!found) begin
      run_valid  = 1'b0;
      res.status = pps_pkg::STATUS_IDLE;
      n_idle++;
      return res;
    end

    // The running task holds on to the processor against equal priorities.
    if (run_valid && tsk_valid[run_slot] && tsk_prio[run_slot] == top_prio) begin
      pick = run_slot;
    end else begin
      found = 1'b0;
      for (int s = 0; s < pps_pkg::TASK_SLOTS; s++) begin
        if (tsk_valid[s] && tsk_prio[s] == top_prio) begin
          age = add_seq - tsk_stamp[s];
          if (!found || age > pick_age) begin
            found    = 1'b1;
            pick     = s;
            pick_age = age;
          end
        end
      end
    end

    res.slot = 4'(pick);
    if (tsk_left[pick] <= 16'd1) begin
      tsk_left[pick]  = '0;
      tsk_valid[pick] = 1'b0;
      live_tasks--;
      run_valid       = 1'b0;
      res.task_done   = 1'b1;
      n_finished++;
    end else begin
      tsk_left[pick] = tsk_left[pick] - 16'd1;
      run_valid      = 1'b1;
      run_slot       = pick;
    end
    return res;
  endfunction

  // Called at a clock edge; returns at the edge of the transfer, or after the gap.
  task automatic send_item(pps_pkg::in_item_t it, logic typed, pps_pkg::out_item_t want,
                           int idle_pct);
    pps_pkg::out_item_t guess;
    int                 gap;
    gap = 0;
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    guess = next_schedule_result(it);
    due_results.push_back(typed ? want : guess);
    while ($urandom_range(0, 99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_phase(logic mode, int idle_pct, int stall_level, int n_items);
    pps_pkg::in_item_t it;
    int                tick_pct;
    int                r;
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= mode;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    high_wins = mode;
    stall_pct = stall_level;
    for (int k = 0; k < n_items; k++) begin
      if (live_tasks >= pps_pkg::TASK_SLOTS - 2) tick_pct = 85;
      else if (live_tasks == 0) tick_pct = 35;
      else tick_pct = 55;
      it.command = ($urandom_range(0, 99) < tick_pct) ? pps_pkg::CMD_TICK : pps_pkg::CMD_ADD;
      // Half the priorities come from a small pool so that ties are common.
      it.task_priority = $urandom_range(0, 1) ? 8'($urandom) : tie_prios[$urandom_range(0, 4)];
      r = $urandom_range(0, 199);
      if (r < 170) it.burst_length = 16'($urandom_range(1, 4));
      else if (r < 172) it.burst_length = 16'h0000;
      else if (r < 196) it.burst_length = 16'($urandom_range(5, 40));
      else if (r < 198) it.burst_length = 16'($urandom);
      else it.burst_length = 16'hffff;
      send_item(it, 1'b0, NO_WANT, idle_pct);
    end
    in_valid_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (due_results.size() == 0) begin
        err_count++;
        if (err_count <= MAX_REPORTS)
          $display("%0t: unexpected result, status/slot/done/time %0d/%0d/%0d/%0d",
                   $time, out_data_o.status, out_data_o.slot, out_data_o.task_done,
                   out_data_o.time_now);
      end else begin
        want_now = due_results.pop_front();
        if (out_data_o.status !== want_now.status || out_data_o.slot !== want_now.slot ||
            out_data_o.task_done !== want_now.task_done ||
            out_data_o.time_now !== want_now.time_now) begin
          err_count++;
          if (err_count <= MAX_REPORTS)
            $display("%0t: status/slot/done/time expected %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
                     $time, want_now.status, want_now.slot, want_now.task_done,
                     want_now.time_now, out_data_o.status, out_data_o.slot,
                     out_data_o.task_done, out_data_o.time_now);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("%0t: timed out with %0d results outstanding", $time, due_results.size());
      $display("preemptive_priority_scheduler_tb: FAIL");
      $finish;
    end
  end

  initial begin
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    stall_pct  = 0;
    n_adds     = 0;
    n_full     = 0;
    n_ticks    = 0;
    n_idle     = 0;
    n_finished = 0;
    high_wins  = 1'b1;
    run_valid  = 1'b0;
    run_slot   = 0;
    sched_now  = '0;
    add_seq    = '0;
    live_tasks = 0;
    for (int s = 0; s < pps_pkg::TASK_SLOTS; s++) begin
      tsk_valid[s] = 1'b0;
      tsk_prio[s]  = '0;
      tsk_left[s]  = '0;
      tsk_stamp[s] = '0;
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i])
      send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want, 0);
    in_valid_i <= 1'b0;

    run_phase(1'b1, 0,  0,  PHASE_ITEMS);
    run_phase(1'b0, 77, 0,  PHASE_ITEMS);
    run_phase(1'b1, 0,  77, PHASE_ITEMS);
    run_phase(1'b0, 14, 14, PHASE_ITEMS);
    drain_results();

    $display("Ran %0d adds (%0d refused on a full table) and %0d ticks",
             n_adds, n_full, n_ticks);
    $display("(%0d idle, %0d tasks finished) in both priority modes under four pacing mixes.",
             n_idle, n_finished);
    if (err_count == 0) begin
      $display("preemptive_priority_scheduler_tb: PASS");
    end else begin
      $display("preemptive_priority_scheduler_tb: FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/pps_pkg.sv
rtl/core/pps_cell.sv
rtl/core/preemptive_priority_scheduler.sv
dv/preemptive_priority_scheduler_tb.sv
